@@ design/ptgs_pkg.sv @@
// Package for the periodic trilinear grid sampler.
// Holds the shared types, register codes and pipeline constants; no dependencies.
`timescale 1ns / 1ps

package ptgs_pkg;

  // Fixed field widths.
  localparam int POS_W     = 32;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int GIDX_W    = 12;
  localparam int FRAC_W    = 16;
  localparam int OUT_W     = 32;

  // Input command codes.
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // Cell magnitude reduction: bits handled per stage and the stage count.
  localparam int MAG_W      = 33;
  localparam int MOD_STEP   = 7;
  localparam int MOD_STAGES = (MAG_W + MOD_STEP - 1) / MOD_STEP;
  localparam int MAG_PAD    = MOD_STAGES * MOD_STEP;

  // Axis pipeline depth: offset, wrap, partial products, sum, magnitude,
  // reduction stages, final index.
  localparam int AX_LAT = MOD_STAGES + 6;

  // Queue between the front and the back.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DOMAIN_LENGTH  = 3'd0,
    REG_INV_SPACING    = 3'd1,
    REG_LINES_IN_USE   = 3'd2,
    REG_FIELD_BASE     = 3'd3,
    REG_FIELD_SCALE    = 3'd4,
    REG_MOMENTUM_BASE  = 3'd5,
    REG_MOMENTUM_SCALE = 3'd6
  } cfg_reg_t;

  // Configuration register file contents.
  typedef struct packed {
    logic [30:0]        domain_length;
    logic [30:0]        inv_spacing;
    logic [4:0]         lines_in_use;
    logic signed [31:0] field_base;
    logic signed [31:0] field_scale;
    logic signed [31:0] momentum_base;
    logic signed [31:0] momentum_scale;
  } cfg_t;

  // Control part of one queued beat.
  typedef struct packed {
    logic              is_query;
    logic [GIDX_W-1:0] grid_index;
  } qctl_t;

endpackage

@@ design/periodic_trilinear_grid_sampler.sv @@
// Top level of the periodic trilinear grid sampler: ports, configuration
// registers, and the front and back halves. Depends on ptgs_pkg, ptgs_front, ptgs_back.
`timescale 1ns / 1ps
//
//  channel  direction  handshake              payload
//  in_      slave      in_tvalid/in_tready    tdata: grid_index, samples, pos xyz; tuser: cmd
//  out_     master     out_tvalid/out_tready  tdata: field_value, momentum_value
//  cfg_     write      cfg_we                 cfg_index, cfg_data
//
//  One beat per cycle is taken while the queue has room, and one result per cycle is
//  delivered while out_tready is high; a query's result passes through the queue, the
//  axis pipelines (wrap, split multiply, five-stage periodic reduction), then
//  addressing, the store read, the three blend steps, scaling and saturation.
//  Each corner reads its own copy of the grid store, so all eight are read in the same cycle.
//  Reset clears the queue and the valid bits and loads the register defaults; the
//  store is not cleared. A stall at the output freezes the back end while the
//  four-deep queue keeps taking beats until it is full.

module periodic_trilinear_grid_sampler
  import ptgs_pkg::*;
#(
  parameter int GRID_N      = 16,
  parameter int SAMPLE_BITS = 24,
  localparam int IN_BITS    = GIDX_W + 2 * SAMPLE_BITS + 3 * POS_W,
  localparam int IN_W       = ((IN_BITS + 7) / 8) * 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // Fields from bit 0: grid_index, field_sample, momentum_sample, pos_x, pos_y, pos_z.
  input  logic [IN_W-1:0]      in_tdata,
  // Fields from bit 0: cmd.
  input  logic                 in_tuser,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // Fields from bit 0: field_value, momentum_value.
  output logic [2*OUT_W-1:0]   out_tdata,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int SB = SAMPLE_BITS;
  localparam int O_FS = GIDX_W;
  localparam int O_MS = O_FS + SB;
  localparam int O_PX = O_MS + SB;
  localparam int O_PY = O_PX + POS_W;
  localparam int O_PZ = O_PY + POS_W;

  cfg_t  cfg_r, cfg_nxt;
  qctl_t q_ctl;
  logic  q_valid, q_pop;
  logic signed [SB-1:0]    q_fs, q_ms;
  logic signed [POS_W-1:0] q_px, q_py, q_pz;
  logic signed [OUT_W-1:0] out_field, out_momentum;

  // Configuration register writes.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_DOMAIN_LENGTH:  cfg_nxt.domain_length  = cfg_data[30:0];
        REG_INV_SPACING:    cfg_nxt.inv_spacing    = cfg_data[30:0];
        REG_LINES_IN_USE:   cfg_nxt.lines_in_use   = cfg_data[4:0];
        REG_FIELD_BASE:     cfg_nxt.field_base     = cfg_data;
        REG_FIELD_SCALE:    cfg_nxt.field_scale    = cfg_data;
        REG_MOMENTUM_BASE:  cfg_nxt.momentum_base  = cfg_data;
        REG_MOMENTUM_SCALE: cfg_nxt.momentum_scale = cfg_data;
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.domain_length  <= 31'd1048576;
      cfg_r.inv_spacing    <= 31'd65536;
      cfg_r.lines_in_use   <= 5'd16;
      cfg_r.field_base     <= 32'sd0;
      cfg_r.field_scale    <= 32'sd65536;
      cfg_r.momentum_base  <= 32'sd0;
      cfg_r.momentum_scale <= 32'sd65536;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Accept, classify and queue.
  ptgs_front #(.GRID_N(GRID_N), .SAMPLE_BITS(SB)) u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_tvalid),
    .in_ready           (in_tready),
    .in_cmd             (in_tuser),
    .in_grid_index      (in_tdata[GIDX_W-1:0]),
    .in_field_sample    (in_tdata[O_FS +: SB]),
    .in_momentum_sample (in_tdata[O_MS +: SB]),
    .in_pos_x           (in_tdata[O_PX +: POS_W]),
    .in_pos_y           (in_tdata[O_PY +: POS_W]),
    .in_pos_z           (in_tdata[O_PZ +: POS_W]),
    .q_valid            (q_valid),
    .q_ctl              (q_ctl),
    .q_field_sample     (q_fs),
    .q_momentum_sample  (q_ms),
    .q_pos_x            (q_px),
    .q_pos_y            (q_py),
    .q_pos_z            (q_pz),
    .q_pop              (q_pop)
  );

  // Store, sample and deliver.
  ptgs_back #(.GRID_N(GRID_N), .SAMPLE_BITS(SB)) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .q_valid           (q_valid),
    .q_ctl             (q_ctl),
    .q_field_sample    (q_fs),
    .q_momentum_sample (q_ms),
    .q_pos_x           (q_px),
    .q_pos_y           (q_py),
    .q_pos_z           (q_pz),
    .q_pop             (q_pop),
    .out_valid         (out_tvalid),
    .out_ready         (out_tready),
    .out_field         (out_field),
    .out_momentum      (out_momentum)
  );

  assign out_tdata = {out_momentum, out_field};

endmodule

@@ design/ptgs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ptgs_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ design/ptgs_front.sv @@
// Front end: accepts input beats, drops out-of-range loads, and queues the rest.
// Depends on ptgs_pkg.
`timescale 1ns / 1ps

module ptgs_front
  import ptgs_pkg::*;
#(
  parameter int GRID_N      = 16,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_cmd,
  input  logic [GIDX_W-1:0]             in_grid_index,
  input  logic signed [SAMPLE_BITS-1:0] in_field_sample,
  input  logic signed [SAMPLE_BITS-1:0] in_momentum_sample,
  input  logic signed [POS_W-1:0]       in_pos_x,
  input  logic signed [POS_W-1:0]       in_pos_y,
  input  logic signed [POS_W-1:0]       in_pos_z,
  output logic                          q_valid,
  output qctl_t                         q_ctl,
  output logic signed [SAMPLE_BITS-1:0] q_field_sample,
  output logic signed [SAMPLE_BITS-1:0] q_momentum_sample,
  output logic signed [POS_W-1:0]       q_pos_x,
  output logic signed [POS_W-1:0]       q_pos_y,
  output logic signed [POS_W-1:0]       q_pos_z,
  input  logic                          q_pop
);

  localparam int DEPTH = GRID_N * GRID_N * GRID_N;

  qctl_t                         ctl_mem_r [QDEPTH];
  logic signed [SAMPLE_BITS-1:0] fs_mem_r  [QDEPTH];
  logic signed [SAMPLE_BITS-1:0] ms_mem_r  [QDEPTH];
  logic signed [POS_W-1:0]       px_mem_r  [QDEPTH];
  logic signed [POS_W-1:0]       py_mem_r  [QDEPTH];
  logic signed [POS_W-1:0]       pz_mem_r  [QDEPTH];

  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              keep, push, pop;

  // Classify: queries always go on, loads only inside the store.
  assign keep     = (in_cmd == CMD_SAMPLE) ||
                    ({20'd0, in_grid_index} < 32'(DEPTH));
  assign in_ready = (count_r != QCNT_W'(QDEPTH));
  assign push     = in_valid && in_ready && keep;
  assign q_valid  = (count_r != '0);
  assign pop      = q_pop && q_valid;

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      ctl_mem_r[wr_ptr_r] <= '{is_query: in_cmd, grid_index: in_grid_index};
      fs_mem_r[wr_ptr_r]  <= in_field_sample;
      ms_mem_r[wr_ptr_r]  <= in_momentum_sample;
      px_mem_r[wr_ptr_r]  <= in_pos_x;
      py_mem_r[wr_ptr_r]  <= in_pos_y;
      pz_mem_r[wr_ptr_r]  <= in_pos_z;
    end
  end

  assign q_ctl             = ctl_mem_r[rd_ptr_r];
  assign q_field_sample    = fs_mem_r[rd_ptr_r];
  assign q_momentum_sample = ms_mem_r[rd_ptr_r];
  assign q_pos_x           = px_mem_r[rd_ptr_r];
  assign q_pos_y           = py_mem_r[rd_ptr_r];
  assign q_pos_z           = pz_mem_r[rd_ptr_r];

endmodule

@@ design/ptgs_axis.sv @@
// One axis of the position path: offset, wrap, scale, and periodic cell index.
// Depends on ptgs_pkg.
`timescale 1ns / 1ps

module ptgs_axis
  import ptgs_pkg::*;
#(
  parameter int GRID_N = 16,
  localparam int NW = $clog2(GRID_N + 1),
  localparam int IW = $clog2(GRID_N)
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [POS_W-1:0] pos,
  input  logic [30:0]             domain_length,
  input  logic [30:0]             inv_spacing,
  input  logic [NW-1:0]           n,
  output logic [IW-1:0]           lo,
  output logic [IW-1:0]           hi,
  output logic [FRAC_W-1:0]       frac
);

  localparam int RW = NW + 1;

  logic signed [33:0] p0_r, p_r, p_nxt, lenx;
  logic signed [50:0] pl_r;
  logic signed [49:0] ph_r;
  logic signed [65:0] prod;
  logic signed [33:0] cell_r;
  logic [FRAC_W-1:0]  frac_r [MOD_STAGES+3];
  logic [MAG_PAD-1:0] mag_r  [MOD_STAGES+1];
  logic [RW-1:0]      rem_r  [MOD_STAGES+1];
  logic [RW-1:0]      rem_nxt[MOD_STAGES+1];
  logic               neg_r  [MOD_STAGES+1];
  logic [33:0]        mag0;
  logic [RW-1:0]      lo_full, hi_full;
  logic [IW-1:0]      lo_r, hi_r;

  assign lenx = $signed({3'b000, domain_length});

  // Single wrap into the domain.
  always_comb begin
    if (p0_r[33]) begin
      p_nxt = p0_r + lenx;
    end else if (p0_r > lenx) begin
      p_nxt = p0_r - lenx;
    end else begin
      p_nxt = p0_r;
    end
  end

  // Recombine the two partial products into the Q34.32 coordinate.
  assign prod = $signed({{15{pl_r[50]}}, pl_r}) + ($signed({{16{ph_r[49]}}, ph_r}) <<< 16);
  assign mag0 = cell_r[33] ? (~cell_r + 34'd1) : cell_r;

  // Restoring remainder, MOD_STEP bits of the magnitude per stage.
  always_comb begin
    logic [RW-1:0] r;
    rem_nxt[0] = '0;
    for (int s = 1; s <= MOD_STAGES; s++) begin
      r = rem_r[s-1];
      for (int t = 0; t < MOD_STEP; t++) begin
        r = {r[RW-2:0], mag_r[s-1][MAG_PAD-1-((s-1)*MOD_STEP+t)]};
        if (r >= {1'b0, n}) begin
          r = r - {1'b0, n};
        end
      end
      rem_nxt[s] = r;
    end
  end

  // Floor modulo for negative cells, then the periodic upper neighbor.
  always_comb begin
    if (neg_r[MOD_STAGES] && (rem_r[MOD_STAGES] != '0)) begin
      lo_full = {1'b0, n} - rem_r[MOD_STAGES];
    end else begin
      lo_full = rem_r[MOD_STAGES];
    end
    if (lo_full == ({1'b0, n} - 1'b1)) begin
      hi_full = '0;
    end else begin
      hi_full = lo_full + 1'b1;
    end
  end

  // Pipeline registers, all held while the back end stalls.
  always_ff @(posedge clk) begin
    if (en) begin
      p0_r      <= $signed({{2{pos[31]}}, pos}) + $signed({4'b0000, domain_length[30:1]});
      p_r       <= p_nxt;
      pl_r      <= p_r * $signed({1'b0, inv_spacing[15:0]});
      ph_r      <= p_r * $signed({1'b0, inv_spacing[30:16]});
      cell_r    <= prod[65:32];
      frac_r[0] <= prod[31:16];
      for (int k = 1; k < MOD_STAGES + 3; k++) begin
        frac_r[k] <= frac_r[k-1];
      end
      mag_r[0] <= MAG_PAD'(mag0);
      neg_r[0] <= cell_r[33];
      rem_r[0] <= rem_nxt[0];
      for (int s = 1; s <= MOD_STAGES; s++) begin
        mag_r[s] <= mag_r[s-1];
        neg_r[s] <= neg_r[s-1];
        rem_r[s] <= rem_nxt[s];
      end
      lo_r <= lo_full[IW-1:0];
      hi_r <= hi_full[IW-1:0];
    end
  end

  assign lo   = lo_r;
  assign hi   = hi_r;
  assign frac = frac_r[MOD_STAGES+2];

endmodule

@@ design/ptgs_back.sv @@
// Back end: axis pipelines, corner addressing, eight store copies,
// trilinear blend, scale and saturation, and the output register.
// Depends on ptgs_pkg, ptgs_axis and ptgs_ram.
`timescale 1ns / 1ps

module ptgs_back
  import ptgs_pkg::*;
#(
  parameter int GRID_N      = 16,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cfg_t                          cfg,
  input  logic                          q_valid,
  input  qctl_t                         q_ctl,
  input  logic signed [SAMPLE_BITS-1:0] q_field_sample,
  input  logic signed [SAMPLE_BITS-1:0] q_momentum_sample,
  input  logic signed [POS_W-1:0]       q_pos_x,
  input  logic signed [POS_W-1:0]       q_pos_y,
  input  logic signed [POS_W-1:0]       q_pos_z,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [OUT_W-1:0]       out_field,
  output logic signed [OUT_W-1:0]       out_momentum
);

  localparam int SB    = SAMPLE_BITS;
  localparam int SF    = SB - 4;
  localparam int NW    = $clog2(GRID_N + 1);
  localparam int IW    = $clog2(GRID_N);
  localparam int DEPTH = GRID_N * GRID_N * GRID_N;
  localparam int AW    = $clog2(DEPTH);
  localparam int RWD   = $clog2(GRID_N * GRID_N);
  localparam int MW    = RWD + NW + 1;
  localparam int CL    = AX_LAT + 2;
  localparam int NSV   = 9;
  localparam int PW    = SB + 18;
  localparam int SW    = PW + 1;
  localparam int FPW   = 32 + SB;
  localparam int RW2   = FPW + 1;
  localparam int SSW   = RW2 + 1;

  logic               adv;
  logic [NW-1:0]      n_use;

  // Control line alongside the axis pipelines, through the address stage.
  logic [CL-1:0]      cv_r, cq_r;
  logic [GIDX_W-1:0]  cidx_r [CL];
  logic [SB-1:0]      cfs_r  [CL];
  logic [SB-1:0]      cms_r  [CL];

  logic [IW-1:0]      ax_lo [3];
  logic [IW-1:0]      ax_hi [3];
  logic [FRAC_W-1:0]  ax_fr [3];

  logic [RWD-1:0]     row_r  [2][2];
  logic [IW-1:0]      k_r    [2];
  logic [AW-1:0]      addr_r [2][2][2];
  logic [FRAC_W-1:0]  fr_row_r [3];
  logic [FRAC_W-1:0]  fr_addr_r[3];
  logic [FRAC_W-1:0]  fr_rd_r  [3];
  logic [FRAC_W-1:0]  fyz_x1_r [2];
  logic [FRAC_W-1:0]  fyz_x2_r [2];
  logic [FRAC_W-1:0]  fz_y1_r, fz_y2_r;

  logic [2*SB-1:0]    rd [2][2][2];
  logic               ram_we;

  logic [NSV-1:0]     sv_r;
  logic signed [PW-1:0] x1a_r [2][2][2];
  logic signed [PW-1:0] x1b_r [2][2][2];
  logic signed [SB-1:0] cx_r  [2][2][2];
  logic signed [PW-1:0] y1a_r [2][2];
  logic signed [PW-1:0] y1b_r [2][2];
  logic signed [SB-1:0] cy_r  [2][2];
  logic signed [PW-1:0] z1a_r [2];
  logic signed [PW-1:0] z1b_r [2];
  logic signed [SB-1:0] cz_r  [2];
  logic signed [FPW-1:0] fp_r [2];
  logic signed [RW2-1:0] rn_r [2];
  logic signed [31:0]    base [2];
  logic signed [31:0]    scale[2];
  logic signed [OUT_W-1:0] out_r [2];
  logic signed [OUT_W-1:0] sat_nxt [2];
  logic                    out_valid_r;

  // Weighted product of one sample.
  function automatic logic signed [PW-1:0] wprod(input logic signed [SB-1:0] v,
                                                 input logic [17:0] w);
    return v * $signed(w);
  endfunction

  // Sum of two weighted products, rounded half up back to sample precision.
  function automatic logic signed [SB-1:0] blend(input logic signed [PW-1:0] a,
                                                 input logic signed [PW-1:0] b);
    logic signed [SW-1:0] s;
    s = $signed({a[PW-1], a}) + $signed({b[PW-1], b}) + $signed(SW'(1 << (FRAC_W - 1)));
    s = s >>> FRAC_W;
    return s[SB-1:0];
  endfunction

  function automatic logic [17:0] wlo(input logic [FRAC_W-1:0] f);
    return 18'd65536 - {2'b00, f};
  endfunction

  function automatic logic [17:0] whi(input logic [FRAC_W-1:0] f);
    return {2'b00, f};
  endfunction

  // The whole back end moves unless a finished result is waiting.
  assign adv   = !out_valid_r || out_ready;
  assign q_pop = adv && q_valid;

  // Grid size in use, held inside [2, GRID_N].
  always_comb begin
    if (cfg.lines_in_use < 5'd2) begin
      n_use = NW'(2);
    end else if (32'(cfg.lines_in_use) > 32'(GRID_N)) begin
      n_use = NW'(GRID_N);
    end else begin
      n_use = NW'(cfg.lines_in_use);
    end
  end

  // Per-axis position pipelines.
  ptgs_axis #(.GRID_N(GRID_N)) u_ax_x (
    .clk(clk), .en(adv), .pos(q_pos_x), .domain_length(cfg.domain_length),
    .inv_spacing(cfg.inv_spacing), .n(n_use), .lo(ax_lo[0]), .hi(ax_hi[0]), .frac(ax_fr[0])
  );
  ptgs_axis #(.GRID_N(GRID_N)) u_ax_y (
    .clk(clk), .en(adv), .pos(q_pos_y), .domain_length(cfg.domain_length),
    .inv_spacing(cfg.inv_spacing), .n(n_use), .lo(ax_lo[1]), .hi(ax_hi[1]), .frac(ax_fr[1])
  );
  ptgs_axis #(.GRID_N(GRID_N)) u_ax_z (
    .clk(clk), .en(adv), .pos(q_pos_z), .domain_length(cfg.domain_length),
    .inv_spacing(cfg.inv_spacing), .n(n_use), .lo(ax_lo[2]), .hi(ax_hi[2]), .frac(ax_fr[2])
  );

  // Valid bits of the control line and of the blend stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_r        <= '0;
      sv_r        <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      cv_r        <= {cv_r[CL-2:0], q_valid};
      sv_r        <= {sv_r[NSV-2:0], cv_r[CL-1] && cq_r[CL-1]};
      out_valid_r <= sv_r[NSV-1];
    end
  end

  // Beat payload carried along the control line.
  always_ff @(posedge clk) begin
    if (adv) begin
      cq_r      <= {cq_r[CL-2:0], q_ctl.is_query};
      cidx_r[0] <= q_ctl.grid_index;
      cfs_r[0]  <= q_field_sample;
      cms_r[0]  <= q_momentum_sample;
      for (int k = 1; k < CL; k++) begin
        cidx_r[k] <= cidx_r[k-1];
        cfs_r[k]  <= cfs_r[k-1];
        cms_r[k]  <= cms_r[k-1];
      end
    end
  end

  // Row and corner addresses: (i*n + j)*n + k.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int x = 0; x < 2; x++) begin
        for (int a = 0; a < 2; a++) begin
          row_r[x][a] <= RWD'(MW'(x == 0 ? ax_lo[0] : ax_hi[0]) * MW'(n_use) +
                              MW'(a == 0 ? ax_lo[1] : ax_hi[1]));
        end
      end
      k_r[0] <= ax_lo[2];
      k_r[1] <= ax_hi[2];
      for (int x = 0; x < 2; x++) begin
        for (int a = 0; a < 2; a++) begin
          for (int b = 0; b < 2; b++) begin
            addr_r[x][a][b] <= AW'(MW'(row_r[x][a]) * MW'(n_use) + MW'(k_r[b]));
          end
        end
      end
      for (int d = 0; d < 3; d++) begin
        fr_row_r[d]  <= ax_fr[d];
        fr_addr_r[d] <= fr_row_r[d];
        fr_rd_r[d]   <= fr_addr_r[d];
      end
    end
  end

  // Eight copies of the store: every load writes all of them, each corner reads one.
  assign ram_we = adv && cv_r[CL-1] && !cq_r[CL-1];

  for (genvar gx = 0; gx < 2; gx++) begin : g_x
    for (genvar ga = 0; ga < 2; ga++) begin : g_a
      for (genvar gb = 0; gb < 2; gb++) begin : g_b
        ptgs_ram #(.WIDTH(2 * SB), .DEPTH(DEPTH)) u_ram (
          .clk   (clk),
          .we    (ram_we),
          .waddr (AW'(cidx_r[CL-1])),
          .wdata ({cms_r[CL-1], cfs_r[CL-1]}),
          .re    (adv),
          .raddr (addr_r[gx][ga][gb]),
          .rdata (rd[gx][ga][gb])
        );
      end
    end
  end

  assign base[0]  = cfg.field_base;
  assign base[1]  = cfg.momentum_base;
  assign scale[0] = cfg.field_scale;
  assign scale[1] = cfg.momentum_scale;

  // Saturation of base plus rounded product.
  always_comb begin
    logic signed [SSW-1:0] s;
    for (int t = 0; t < 2; t++) begin
      s = $signed({{(SSW-32){base[t][31]}}, base[t]}) + $signed({rn_r[t][RW2-1], rn_r[t]});
      if ((s[SSW-1:31] == '0) || (s[SSW-1:31] == '1)) begin
        sat_nxt[t] = s[31:0];
      end else if (s[SSW-1]) begin
        sat_nxt[t] = 32'sh8000_0000;
      end else begin
        sat_nxt[t] = 32'sh7FFF_FFFF;
      end
    end
  end

  // Blend along x, then y, then z; then scale, round and saturate.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int t = 0; t < 2; t++) begin
        for (int a = 0; a < 2; a++) begin
          for (int b = 0; b < 2; b++) begin
            x1a_r[t][a][b] <= wprod(rd[0][a][b][t*SB +: SB], wlo(fr_rd_r[0]));
            x1b_r[t][a][b] <= wprod(rd[1][a][b][t*SB +: SB], whi(fr_rd_r[0]));
            cx_r[t][a][b]  <= blend(x1a_r[t][a][b], x1b_r[t][a][b]);
          end
        end
        for (int b = 0; b < 2; b++) begin
          y1a_r[t][b] <= wprod(cx_r[t][0][b], wlo(fyz_x2_r[0]));
          y1b_r[t][b] <= wprod(cx_r[t][1][b], whi(fyz_x2_r[0]));
          cy_r[t][b]  <= blend(y1a_r[t][b], y1b_r[t][b]);
        end
        z1a_r[t] <= wprod(cy_r[t][0], wlo(fz_y2_r));
        z1b_r[t] <= wprod(cy_r[t][1], whi(fz_y2_r));
        cz_r[t]  <= blend(z1a_r[t], z1b_r[t]);
        fp_r[t]  <= scale[t] * cz_r[t];
        rn_r[t]  <= ($signed({fp_r[t][FPW-1], fp_r[t]}) +
                     $signed(RW2'(1 << (SF - 1)))) >>> SF;
      end
      fyz_x1_r[0] <= fr_rd_r[1];
      fyz_x1_r[1] <= fr_rd_r[2];
      fyz_x2_r    <= fyz_x1_r;
      fz_y1_r     <= fyz_x2_r[1];
      fz_y2_r     <= fz_y1_r;
      if (sv_r[NSV-1]) begin
        out_r[0] <= sat_nxt[0];
        out_r[1] <= sat_nxt[1];
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_field    = out_r[0];
  assign out_momentum = out_r[1];

  // A query leaving the axis pipelines has corner indexes inside the grid in use.
  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    cv_r[AX_LAT-1] && cq_r[AX_LAT-1] |->
      (NW'(ax_lo[0]) < n_use) && (NW'(ax_hi[0]) < n_use) &&
      (NW'(ax_lo[1]) < n_use) && (NW'(ax_hi[1]) < n_use) &&
      (NW'(ax_lo[2]) < n_use) && (NW'(ax_hi[2]) < n_use))
    else $error("corner index outside grid in use");

  // A stall freezes the valid bits of every stage.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(cv_r) && $stable(sv_r))
    else $error("pipeline moved during a stall");

  // The queue is popped only with a beat present and the pipeline moving.
  a_pop_legal: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid && adv)
    else $error("queue popped while empty or stalled");

  // A new result comes only from a query in the last stage before the output register.
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(sv_r[NSV-1]))
    else $error("result without a query behind it");

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking bench for the periodic trilinear grid sampler: grid loads and
// position queries are checked against an in-bench predictor. Depends on ptgs_pkg.
`timescale 1ns / 1ps

module testbench;
  import ptgs_pkg::*;

  localparam int IN_W = 160;
  localparam int DRAIN_CYCLES = 48;

  typedef struct {
    logic               cmd;
    logic [11:0]        gidx;
    logic signed [23:0] fsamp;
    logic signed [23:0] msamp;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
  } beat_t;

  typedef struct {
    logic [31:0] fval;
    logic [31:0] mval;
  } sample_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata = '0;
  logic              in_tuser = 1'b0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [63:0]       out_tdata;
  logic              cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]  cfg_data = '0;

  // Predictor state: grid mirror and register copy.
  logic signed [23:0] fld_mem [4096];
  logic signed [23:0] mom_mem [4096];
  bit                 loaded [4096];
  longint dom_len = 1048576, inv_sp = 65536, lines = 16;
  longint fbase = 0, fscale = 65536, mbase = 0, mscale = 65536;

  beat_t   pend_q[$];
  sample_t sample_q[$];
  beat_t   cur;
  int      errors = 0;
  bit      idle_on = 1'b1;
  int      in_gap = 0;
  int      out_stall = 0;

  periodic_trilinear_grid_sampler u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic longint lines_eff();
    if (lines < 2) return 2;
    if (lines > 16) return 16;
    return lines;
  endfunction

  // Wrap one coordinate into the domain and split it into cell and fraction.
  function automatic void axis_split(longint pos, output longint lo, output longint hi,
                                     output longint frac);
    longint n, p, prod, m;
    n = lines_eff();
    p = pos + (dom_len >>> 1);
    if (p < 0) p += dom_len;
    else if (p > dom_len) p -= dom_len;
    prod = p * inv_sp;
    frac = (prod >>> 16) & 64'hFFFF;
    m = (prod >>> 32) % n;
    if (m < 0) m += n;
    lo = m;
    hi = (m + 1) % n;
  endfunction

  function automatic longint blend(longint a, longint b, longint f);
    return (a * (65536 - f) + b * f + 32768) >>> 16;
  endfunction

  function automatic logic [31:0] scale_out(longint base, longint scl, longint v);
    longint s;
    s = base + ((scl * v + 524288) >>> 20);
    if (s > 64'sd2147483647) s = 64'sd2147483647;
    if (s < -64'sd2147483648) s = -64'sd2147483648;
    return s[31:0];
  endfunction

  // Returns a corner whose entry was never loaded, or -1 when all eight are.
  function automatic int missing_corner(beat_t b);
    longint n, ix[2], jx[2], kx[2], f;
    n = lines_eff();
    axis_split(b.px, ix[0], ix[1], f);
    axis_split(b.py, jx[0], jx[1], f);
    axis_split(b.pz, kx[0], kx[1], f);
    for (int c = 0; c < 8; c++)
      if (!loaded[(ix[c[2]] * n + jx[c[1]]) * n + kx[c[0]]])
        return int'((ix[c[2]] * n + jx[c[1]]) * n + kx[c[0]]);
    return -1;
  endfunction

  function automatic sample_t interpolate(beat_t b);
    longint n, ix[2], jx[2], kx[2], fx, fy, fz, cf[4], cm[4], vf, vm, r0, r1;
    sample_t res;
    n = lines_eff();
    axis_split(b.px, ix[0], ix[1], fx);
    axis_split(b.py, jx[0], jx[1], fy);
    axis_split(b.pz, kx[0], kx[1], fz);
    for (int c = 0; c < 4; c++) begin
      r0 = (ix[0] * n + jx[c[1]]) * n + kx[c[0]];
      r1 = (ix[1] * n + jx[c[1]]) * n + kx[c[0]];
      cf[c] = blend(fld_mem[r0], fld_mem[r1], fx);
      cm[c] = blend(mom_mem[r0], mom_mem[r1], fx);
    end
    vf = blend(blend(cf[0], cf[2], fy), blend(cf[1], cf[3], fy), fz);
    vm = blend(blend(cm[0], cm[2], fy), blend(cm[1], cm[3], fy), fz);
    res.fval = scale_out(fbase, fscale, vf);
    res.mval = scale_out(mbase, mscale, vm);
    return res;
  endfunction

  task automatic push_load(int idx, logic signed [23:0] fs, logic signed [23:0] ms);
    beat_t b;
    b = '{CMD_LOAD, idx[11:0], fs, ms, $urandom, $urandom, $urandom};
    loaded[idx] = 1'b1;
    pend_q.push_back(b);
  endtask

  // A query goes out only after every corner it touches has been loaded.
  task automatic push_query(logic signed [31:0] x, logic signed [31:0] y, logic signed [31:0] z);
    beat_t b;
    int idx;
    b = '{CMD_SAMPLE, 12'($urandom), 24'($urandom), 24'($urandom), x, y, z};
    idx = missing_corner(b);
    while (idx >= 0) begin
      push_load(idx, 24'($urandom), 24'($urandom));
      idx = missing_corner(b);
    end
    pend_q.push_back(b);
  endtask

  function automatic logic signed [31:0] rand_pos();
    int mode;
    mode = $urandom_range(0, 9);
    if (mode < 7)
      return 32'($urandom_range(0, 32'(dom_len)) - (dom_len >>> 1));
    if (mode < 9)
      return 32'((longint'($urandom_range(0, 20)) << 16) - (dom_len >>> 1));
    return $urandom;
  endfunction

  task automatic cfg_write(cfg_reg_t idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_DOMAIN_LENGTH:  dom_len = val[30:0];
      REG_INV_SPACING:    inv_sp = val[30:0];
      REG_LINES_IN_USE:   lines = val[4:0];
      REG_FIELD_BASE:     fbase = $signed(val);
      REG_FIELD_SCALE:    fscale = $signed(val);
      REG_MOMENTUM_BASE:  mbase = $signed(val);
      REG_MOMENTUM_SCALE: mscale = $signed(val);
      default: ;
    endcase
  endtask

  task automatic write_all(logic [31:0] len, logic [31:0] inv, logic [31:0] ln,
                           logic [31:0] fb, logic [31:0] fs, logic [31:0] mb,
                           logic [31:0] ms);
    cfg_write(REG_DOMAIN_LENGTH, len);
    cfg_write(REG_INV_SPACING, inv);
    cfg_write(REG_LINES_IN_USE, ln);
    cfg_write(REG_FIELD_BASE, fb);
    cfg_write(REG_FIELD_SCALE, fs);
    cfg_write(REG_MOMENTUM_BASE, mb);
    cfg_write(REG_MOMENTUM_SCALE, ms);
  endtask

  // Checked between edges, so that the driver's updates of this cycle are seen.
  task automatic drain();
    while (pend_q.size() != 0 || sample_q.size() != 0 || in_tvalid) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Random mix: mostly queries over loaded cells, some loads anywhere.
  task automatic random_phase(int count);
    beat_t b;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        push_load($urandom_range(0, 4095), 24'($urandom), 24'($urandom));
      end else begin
        b.cmd = CMD_SAMPLE;
        for (int t = 0; t < 6; t++) begin
          b.px = rand_pos();
          b.py = rand_pos();
          b.pz = rand_pos();
          if (missing_corner(b) < 0) break;
        end
        push_query(b.px, b.py, b.pz);
      end
    end
  endtask

  // Input driver: predicts each accepted beat and presents the next one.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        if (cur.cmd == CMD_LOAD) begin
          fld_mem[cur.gidx] = cur.fsamp;
          mom_mem[cur.gidx] = cur.msamp;
        end else begin
          sample_q.push_back(interpolate(cur));
        end
      end
      if (!(in_tvalid && !in_tready)) begin
        if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (pend_q.size() != 0) begin
          cur = pend_q.pop_front();
          in_tdata <= {4'b0, cur.pz, cur.py, cur.px, cur.msamp, cur.fsamp, cur.gidx};
          in_tuser <= cur.cmd;
          in_tvalid <= 1'b1;
          if (idle_on && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 7);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output monitor with random backpressure.
  always @(posedge clk) begin
    sample_t exp_s;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (sample_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, out_tdata);
          errors++;
        end else begin
          exp_s = sample_q.pop_front();
          if (out_tdata[31:0] !== exp_s.fval) begin
            $display("%0t: field_value expected %h actual %h", $time, exp_s.fval,
                     out_tdata[31:0]);
            errors++;
          end
          if (out_tdata[63:32] !== exp_s.mval) begin
            $display("%0t: momentum_value expected %h actual %h", $time, exp_s.mval,
                     out_tdata[63:32]);
            errors++;
          end
        end
      end
      if (out_stall > 0) begin
        out_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (idle_on && $urandom_range(0, 5) == 0) out_stall = $urandom_range(1, 7);
      end
    end
  end

  initial begin
    #40_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    longint n, inv;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extreme samples, grid points, domain edge, far-out positions.
    push_load(0, 24'sh7FFFFF, -24'sh800000);
    push_load(1, -24'sh800000, 24'sh7FFFFF);
    push_load(4095, 24'sh000000, 24'sh000001);
    push_query(0, 0, 0);
    push_query(-32'sh80000, -32'sh80000, -32'sh80000);
    push_query(32'sh80000, 32'sh80000, 32'sh80000);
    push_query(32'sh7FFFFFFF, -32'sh80000000, 32'sh8000);
    push_query(-32'sh80000000, 32'sh7FFFFFFF, -32'sh7FFF8000);
    push_query(32'sh18000, -32'sh7C000, 32'sh7FFFF);
    push_query(-32'sh1, 32'sh1, 32'sh3FFFF);
    drain();

    // Saturating scales, lines below range, tiny domain.
    write_all(32'h0002_0000, 32'h0001_0000, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              32'h8000_0000, 32'h8000_0000);
    push_query(0, 0, 0);
    push_query(32'sh10000, -32'sh8000, 32'sh7FFFFFFF);
    random_phase(150);
    drain();

    // Largest domain and spacing, lines above range.
    write_all(32'h7FFF_FFFF, 32'h7FFF_FFFF, 31, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF,
              32'h7FFF_FFFF);
    push_query(32'sh7FFFFFFF, 32'sh7FFFFFFF, -32'sh80000000);
    random_phase(40);
    drain();

    // Zero domain and zero spacing.
    write_all(32'h0, 32'h0, 2, 32'h1234_5678, 32'h0, 32'hFFFF_0000, 32'h0001_8000);
    push_query(32'sh12345, -32'sh80000000, 32'sh7FFFFFFF);
    random_phase(80);
    drain();

    // Random settings that map the domain onto the grid in use.
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 5) idle_on = 1'b0;
      n = $urandom_range(2, 16);
      dom_len = $urandom_range(32'h100, 32'h100_0000);
      inv = ((n << 32) / dom_len) + $urandom_range(0, 3) - 1;
      write_all(32'(dom_len), 32'(inv), 32'(n), $urandom_range(0, 1) ? $urandom : 0,
                $urandom_range(0, 1) ? $urandom : 32'($urandom_range(0, 32'h40000)),
                $urandom_range(0, 1) ? $urandom : 0,
                $signed(32'($urandom_range(0, 32'h40000))) - 32'sh20000);
      random_phase(ph == 5 ? 120 : 80);
      drain();
    end

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
